/* hdl/life_grid_generation_step_assert.svh */
// assertion macros for the life grid generation step block
// no dependencies; included by the files that carry checks
`ifndef LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define LGS_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
// next-cycle implication, checked outside reset
`define LGS_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define LGS_ASSERT_IMP(name, ck, rs, ante, cons)
`define LGS_ASSERT_NEXT(name, ck, rs, ante, cons)
`endif
`endif

/* hdl/lgs_pkg.sv */
// shared types and constants for the life grid generation step block
// no dependencies
package lgs_pkg;

  // request modes
  localparam logic [1:0] MODE_SET     = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  // b3/s23 neighbour counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // control of the three-row window held in the cell chain
  typedef struct packed {
    logic clear;
    logic shift;
  } lgs_win_ctrl_t;

endpackage

/* hdl/lgs_cell.sv */
// one column cell: holds a three-row window of its column and works out
// the next state of the middle row; depends on lgs_pkg
module lgs_cell
  import lgs_pkg::*;
(
  input  logic          clk,
  input  lgs_win_ctrl_t ctrl,
  input  logic          bit_in,
  input  logic [2:0]    left_col,
  input  logic [2:0]    right_col,
  output logic [2:0]    col,
  output logic          next_bit
);

  logic       up;
  logic       mid;
  logic       down;
  logic [3:0] count;

  // window shifts one row down per sweep step
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      up   <= 1'b0;
      mid  <= 1'b0;
      down <= 1'b0;
    end else if (ctrl.shift) begin
      up   <= mid;
      mid  <= down;
      down <= bit_in;
    end
  end

  // column handed to both neighbours, bit 0 is the upper row
  assign col = {down, mid, up};

  // eight neighbour count and rule
  always_comb begin
    count = 4'(left_col[0]) + 4'(left_col[1]) + 4'(left_col[2])
          + 4'(right_col[0]) + 4'(right_col[1]) + 4'(right_col[2])
          + 4'(up) + 4'(down);
    next_bit = (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && mid);
  end

endmodule

/* hdl/lgs_cell_row.sv */
// chain of column cells spanning one grid row; cells beyond the edges
// read as dead; depends on lgs_pkg and lgs_cell
module lgs_cell_row
  import lgs_pkg::*;
#(
  parameter int GRID_WIDTH = 64
) (
  input  logic                  clk,
  input  lgs_win_ctrl_t         ctrl,
  input  logic [GRID_WIDTH-1:0] row_in,
  output logic [GRID_WIDTH-1:0] row_next
);

  logic [2:0] win [GRID_WIDTH];

  for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
    logic [2:0] left_col;
    logic [2:0] right_col;

    // dead cells past the grid edges
    if (c == 0) begin : g_left_edge
      assign left_col = 3'b000;
    end else begin : g_left
      assign left_col = win[c-1];
    end
    if (c == GRID_WIDTH - 1) begin : g_right_edge
      assign right_col = 3'b000;
    end else begin : g_right
      assign right_col = win[c+1];
    end

    lgs_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (row_in[c]),
      .left_col (left_col),
      .right_col(right_col),
      .col      (win[c]),
      .next_bit (row_next[c])
    );
  end

endmodule

/* hdl/life_grid_generation_step.sv */
// life grid generation step (b3/s23): a grid of one-bit cells held as one row
// per memory word. After reset a clearing pass writes every row dead, during
// which no request is taken. A set or read request passes through row read,
// row use and result load in turn. An advance sweeps the grid one row per
// cycle through a chain of column cells holding a three-row window, with the
// new row written back in place three rows behind the row being read.
// Mode 3 and addresses outside the grid answer 0 and change nothing.
// The result waits in an output register.
// Depends on lgs_pkg, lgs_cell_row and the assertion header.
`include "life_grid_generation_step_assert.svh"

module life_grid_generation_step
  import lgs_pkg::*;
#(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [5:0] cell_x,
  input  logic [5:0] cell_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       alive
);

  localparam int CW        = $clog2(GRID_WIDTH);
  localparam int RW        = $clog2(GRID_HEIGHT);
  localparam int SW        = $clog2(GRID_HEIGHT + 3);
  localparam int ADV_LAG   = 3;
  localparam int LAST_STEP = GRID_HEIGHT + 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_USE,
    ST_ADV,
    ST_OUT
  } state_t;

  state_t                state;
  logic [1:0]            item_mode;
  logic [CW-1:0]         item_col;
  logic [RW-1:0]         item_row;
  logic [RW-1:0]         clr_row;
  logic [SW-1:0]         step;
  logic                  res;
  logic                  rd_ok;
  logic                  item_inside;
  logic                  out_load;

  logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];
  logic [GRID_WIDTH-1:0] rdata;
  logic                  mem_we;
  logic                  mem_re;
  logic [RW-1:0]         mem_waddr;
  logic [RW-1:0]         mem_raddr;
  logic [GRID_WIDTH-1:0] mem_wdata;

  lgs_win_ctrl_t         win_ctrl;
  logic [GRID_WIDTH-1:0] row_in;
  logic [GRID_WIDTH-1:0] row_next;

  assign in_stall    = (state != ST_IDLE);
  assign item_inside = (32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT);

  // finished request moves into the output register
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = clr_row;
    mem_raddr = item_row;
    mem_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_RD: begin
        mem_re = 1'b1;
      end
      ST_USE: begin
        mem_we    = (item_mode == MODE_SET);
        mem_waddr = item_row;
        mem_wdata = rdata | (GRID_WIDTH'(1) << item_col);
      end
      ST_ADV: begin
        mem_re    = (step < SW'(GRID_HEIGHT));
        mem_raddr = RW'(step);
        mem_we    = (step >= SW'(ADV_LAG));
        mem_waddr = RW'(step - SW'(ADV_LAG));
        mem_wdata = row_next;
      end
      default: begin
      end
    endcase
  end

  // grid rows, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // rows beyond the bottom edge enter the window as dead
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= mem_re && (state == ST_ADV);
    end
  end

  assign row_in         = rd_ok ? rdata : '0;
  assign win_ctrl.clear = (state == ST_IDLE) && in_valid && (mode == MODE_ADVANCE);
  assign win_ctrl.shift = (state == ST_ADV);

  lgs_cell_row #(
    .GRID_WIDTH(GRID_WIDTH)
  ) u_row (
    .clk     (clk),
    .ctrl    (win_ctrl),
    .row_in  (row_in),
    .row_next(row_next)
  );

  // request sequencing and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_row   <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_row == RW'(GRID_HEIGHT - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_row <= clr_row + RW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            item_mode <= mode;
            item_col  <= CW'(cell_x);
            item_row  <= RW'(cell_y);
            res       <= 1'b0;
            step      <= '0;
            case (mode)
              MODE_SET, MODE_READ: state <= item_inside ? ST_RD : ST_OUT;
              MODE_ADVANCE:        state <= ST_ADV;
              default:             state <= ST_OUT;
            endcase
          end
        end
        ST_RD: begin
          state <= ST_USE;
        end
        ST_USE: begin
          if (item_mode == MODE_READ) begin
            res <= rdata[item_col];
          end
          state <= ST_OUT;
        end
        ST_ADV: begin
          if (step == SW'(LAST_STEP)) begin
            state <= ST_OUT;
          end else begin
            step <= step + SW'(1);
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            alive     <= res;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // in-place sweep never writes the row being fetched
  `LGS_ASSERT_IMP(a_no_rw_clash, clk, rst, mem_we && mem_re, mem_waddr != mem_raddr)
  // sweep counter stays within the sweep
  `LGS_ASSERT_IMP(a_step_range, clk, rst, state == ST_ADV, step <= SW'(LAST_STEP))
  // a finished request lands in the output register
  `LGS_ASSERT_NEXT(a_result_out, clk, rst, out_load, out_valid && (state == ST_IDLE))

endmodule
